/* hdl/mqt_pkg.sv */
// ----------------------------------------------------------------------------
// mqt_pkg
// Shared types and constants for the memory quota tracker.
// ----------------------------------------------------------------------------
package mqt_pkg;

	localparam int LIMIT_BITS      = 31;
	localparam int OWNER_BITS_DEF  = 10;
	localparam int AMOUNT_BITS_DEF = 31;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic sweep;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic is_clear;
	} dp_stat_t;

endpackage

/* hdl/mqt_ctrl.sv */
// ----------------------------------------------------------------------------
// mqt_ctrl
// Sequencer: table sweep after reset, transaction capture and execute,
// table sweep after a clear.
// ----------------------------------------------------------------------------
module mqt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mqt_pkg::dp_stat_t stat,
	output mqt_pkg::ctrl_cmd_t ctrl,
	output logic              busy
);
	import mqt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_SWEEP: begin
				ctrl.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctrl.capture = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctrl.exec = 1'b1;
				state_d   = stat.is_clear ? ST_CLEAR : ST_IDLE;
			end
			ST_CLEAR: begin
				ctrl.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_capture_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.capture |=> (state_q == ST_EXEC))
		else $error("capture not followed by execute");

	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.exec && stat.is_clear) |=> (state_q == ST_CLEAR))
		else $error("clear not followed by sweep");
`endif

endmodule

/* hdl/mqt_dpath.sv */
// ----------------------------------------------------------------------------
// mqt_dpath
// Owner table, running total, allocate/release checks and result stages.
// ----------------------------------------------------------------------------
module mqt_dpath #(
	parameter int OWNER_BITS  = mqt_pkg::OWNER_BITS_DEF,
	parameter int AMOUNT_BITS = mqt_pkg::AMOUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mqt_pkg::ctrl_cmd_t            ctrl,
	output mqt_pkg::dp_stat_t             stat,
	input  logic [1:0]                    command,
	input  logic [OWNER_BITS-1:0]         owner_id,
	input  logic [AMOUNT_BITS-1:0]        amount,
	input  logic [mqt_pkg::LIMIT_BITS-1:0] total_cap,
	input  logic [mqt_pkg::LIMIT_BITS-1:0] per_owner_limit,
	output logic                          done,
	output logic                          granted,
	output logic [AMOUNT_BITS-1:0]        owner_usage,
	output logic [AMOUNT_BITS-1:0]        owner_space_left,
	output logic [AMOUNT_BITS-1:0]        total_usage
);
	import mqt_pkg::*;

	localparam int DEPTH = 1 << OWNER_BITS;
	localparam int AW    = AMOUNT_BITS;
	localparam int CW    = ((AW > LIMIT_BITS) ? AW : LIMIT_BITS) + 1;

	// table entry: {record valid, usage}
	logic [AW:0]           mem_q [DEPTH];
	logic [OWNER_BITS-1:0] sweep_cnt_q;
	logic [AW-1:0]         total_q;

	cmd_e_t                cmd_s1;
	logic [OWNER_BITS-1:0] own_s1;
	logic [AW-1:0]         amt_s1;
	logic [AW:0]           rd_s1;

	logic                  vld_s2;
	logic                  ok_s2;
	logic [AW-1:0]         mine_s2;

	logic                  done_q;
	logic                  granted_q;
	logic [AW-1:0]         usage_q;
	logic [AW-1:0]         left_q;
	logic [AW-1:0]         tot_q;

	logic                  rdv_w;
	logic [AW-1:0]         rdu_w;
	logic [AW-1:0]         base_w;
	logic [AW:0]           sum_w;
	logic [AW:0]           mine_w;
	logic [AW-1:0]         rel_w;
	logic [CW-1:0]         ovl_x;
	logic [CW-1:0]         pol_x;
	logic                  pol_on;
	logic                  refuse_w;
	logic                  ok_w;
	logic                  wr_w;
	logic                  nvld_w;
	logic [AW-1:0]         nuse_w;
	logic [AW-1:0]         ntot_w;
	logic [CW-1:0]         mine2_x;

	assign rdv_w  = rd_s1[AW];
	assign rdu_w  = rd_s1[AW-1:0];
	assign ovl_x  = CW'(total_cap);
	assign pol_x  = CW'(per_owner_limit);
	assign pol_on = (per_owner_limit != '0);

	assign stat.sweep_last = (sweep_cnt_q == '1);
	assign stat.is_clear   = (cmd_s1 == CMD_CLEAR);

	always_comb begin
		base_w   = rdv_w ? rdu_w : '0;
		sum_w    = {1'b0, total_q} + {1'b0, amt_s1};
		mine_w   = {1'b0, base_w} + {1'b0, amt_s1};
		rel_w    = rdu_w - amt_s1;
		refuse_w = sum_w[AW]
			|| ((total_cap != '0) && (CW'(sum_w) > ovl_x))
			|| (pol_on && (CW'(amt_s1) > pol_x));
		ok_w     = 1'b0;
		wr_w     = 1'b0;
		nvld_w   = rdv_w;
		nuse_w   = rdu_w;
		ntot_w   = total_q;
		unique case (cmd_s1)
			CMD_ALLOC: begin
				if (!refuse_w) begin
					wr_w   = 1'b1;
					nvld_w = 1'b1;
					nuse_w = base_w;
					if (!(mine_w[AW] || (pol_on && (CW'(mine_w) > pol_x)))) begin
						ok_w   = 1'b1;
						nuse_w = mine_w[AW-1:0];
						ntot_w = sum_w[AW-1:0];
					end
				end
			end
			CMD_RELEASE: begin
				if (rdv_w && (rdu_w >= amt_s1)) begin
					ok_w   = 1'b1;
					wr_w   = 1'b1;
					nuse_w = rel_w;
					nvld_w = (rel_w != '0);
					ntot_w = (total_q >= amt_s1) ? (total_q - amt_s1) : '0;
				end
			end
			CMD_CLEAR: begin
				ok_w   = 1'b1;
				nvld_w = 1'b0;
				nuse_w = '0;
				ntot_w = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.sweep) begin
			mem_q[sweep_cnt_q] <= '0;
		end else if (ctrl.exec && wr_w) begin
			mem_q[own_s1] <= {nvld_w, nuse_w};
		end
		if (ctrl.capture) begin
			rd_s1 <= mem_q[owner_id];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_s1 <= cmd_e_t'(command);
			own_s1 <= owner_id;
			amt_s1 <= amount;
		end
		if (ctrl.exec) begin
			ok_s2   <= ok_w;
			mine_s2 <= nvld_w ? nuse_w : '0;
		end
		if (vld_s2) begin
			granted_q <= ok_s2;
			usage_q   <= mine_s2;
			tot_q     <= total_q;
			left_q    <= (pol_on && (pol_x > mine2_x)) ? AW'(pol_x - mine2_x) : '0;
		end
	end

	assign mine2_x = CW'(mine_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_cnt_q <= '0;
			total_q     <= '0;
			vld_s2      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (ctrl.sweep) begin
				sweep_cnt_q <= sweep_cnt_q + 1'b1;
			end
			if (ctrl.exec) begin
				total_q <= ntot_w;
			end
			vld_s2 <= ctrl.exec;
			done_q <= vld_s2;
		end
	end

	assign done             = done_q;
	assign granted          = granted_q;
	assign owner_usage      = usage_q;
	assign owner_space_left = left_q;
	assign total_usage      = tot_q;

`ifndef NO_ASSERTIONS
	a_clear_total: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.exec && stat.is_clear) |=> (total_q == '0))
		else $error("total not zero after clear");
`endif

endmodule

/* hdl/memory_quota_tracker.sv */
// ----------------------------------------------------------------------------
// memory_quota_tracker
// Per-owner and overall memory quota tracker with APB limit registers.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken when start is high and busy low.
//   command selects allocate, release or clear; owner_id and amount go with it.
//   Result channel: done pulses for one cycle with granted, owner_usage,
//   owner_space_left and total_usage. The receiver cannot stall; every
//   result must be taken in its done cycle.
//   The transaction is captured with its table read, then executed, and its
//   result is registered before done rises.
//   Busy stays high while a transaction executes, so the next one is taken
//   only after the read-then-write of the owner table through its single
//   registered port. A clear returns its result like any other transaction
//   but keeps busy high while the whole table is swept one entry a cycle.
//   Reset: limits and total go to zero; busy stays high while the whole table
//   is swept. APB writes are taken at any time.
//   Registers: 0x0 overall limit, 0x4 per-owner limit; zero means unlimited.
// ----------------------------------------------------------------------------
module memory_quota_tracker #(
	parameter int OWNER_BITS  = mqt_pkg::OWNER_BITS_DEF,
	parameter int AMOUNT_BITS = mqt_pkg::AMOUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   start,
	input  logic [1:0]             command,
	input  logic [OWNER_BITS-1:0]  owner_id,
	input  logic [AMOUNT_BITS-1:0] amount,
	output logic                   busy,
	output logic                   done,
	output logic                   granted,
	output logic [AMOUNT_BITS-1:0] owner_usage,
	output logic [AMOUNT_BITS-1:0] owner_space_left,
	output logic [AMOUNT_BITS-1:0] total_usage
);
	import mqt_pkg::*;

	localparam logic REG_OVERALL   = 1'b0;
	localparam logic REG_PER_OWNER = 1'b1;

	logic [LIMIT_BITS-1:0] overall_q;
	logic [LIMIT_BITS-1:0] per_owner_q;
	logic                  wr_en;
	ctrl_cmd_t             ctrl;
	dp_stat_t              stat;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overall_q   <= '0;
			per_owner_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_OVERALL:   overall_q   <= pwdata[LIMIT_BITS-1:0];
				REG_PER_OWNER: per_owner_q <= pwdata[LIMIT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_OVERALL:   prdata = 32'(overall_q);
			REG_PER_OWNER: prdata = 32'(per_owner_q);
			default:       prdata = '0;
		endcase
	end

	mqt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	mqt_dpath #(
		.OWNER_BITS  (OWNER_BITS),
		.AMOUNT_BITS (AMOUNT_BITS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (ctrl),
		.stat             (stat),
		.command          (command),
		.owner_id         (owner_id),
		.amount           (amount),
		.total_cap        (overall_q),
		.per_owner_limit  (per_owner_q),
		.done             (done),
		.granted          (granted),
		.owner_usage      (owner_usage),
		.owner_space_left (owner_space_left),
		.total_usage      (total_usage)
	);

`ifndef NO_ASSERTIONS
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result missing three cycles after transaction");
`endif

endmodule

/* test/mqt_tb_pkg.sv */
// ----------------------------------------------------------------------------
// mqt_tb_pkg
// Register map shared by the quota tracker bench and its checker.
// ----------------------------------------------------------------------------
package mqt_tb_pkg;

	localparam logic [2:0] ADDR_OVERALL_LIMIT = 3'h0;
	localparam logic [2:0] ADDR_OWNER_LIMIT   = 3'h4;

endpackage

/* test/mqt_quota_checker.sv */
// ----------------------------------------------------------------------------
// mqt_quota_checker
// Watches the command, result and register ports of the quota tracker. Keeps
// its own owner table, total and limits, works out the reply to each accepted
// transaction and compares every returned result against the oldest one.
// ----------------------------------------------------------------------------
module mqt_quota_checker
	import mqt_pkg::*, mqt_tb_pkg::*;
#(
	parameter int OWNER_BITS  = OWNER_BITS_DEF,
	parameter int AMOUNT_BITS = AMOUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic                   pready,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	input  logic                   start,
	input  logic                   busy,
	input  logic [1:0]             command,
	input  logic [OWNER_BITS-1:0]  owner_id,
	input  logic [AMOUNT_BITS-1:0] amount,
	input  logic                   done,
	input  logic                   granted,
	input  logic [AMOUNT_BITS-1:0] owner_usage,
	input  logic [AMOUNT_BITS-1:0] owner_space_left,
	input  logic [AMOUNT_BITS-1:0] total_usage,
	output int                     pending_replies,
	output int                     mismatch_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [AMOUNT_BITS-1:0] amt_t;
	typedef logic [OWNER_BITS-1:0]  owner_t;

	typedef struct packed {
		logic granted;
		amt_t usage;
		amt_t space_left;
		amt_t total;
	} quota_reply_t;

	localparam logic [63:0] AMOUNT_MAX = (64'd1 << AMOUNT_BITS) - 64'd1;

	quota_reply_t quota_replies[$];
	amt_t         overall_lim;
	amt_t         owner_lim;
	amt_t         total_used;
	amt_t         usage_tbl [2**OWNER_BITS];
	bit           rec_valid [2**OWNER_BITS];

	function automatic quota_reply_t apply_request(cmd_e_t cmd, owner_t who, amt_t amt);
		quota_reply_t r;
		logic [63:0]  sum;
		logic [63:0]  mine;
		logic         ok;
		ok = 1'b0;
		case (cmd)
			CMD_ALLOC: begin
				sum = 64'(total_used) + 64'(amt);
				if (sum <= AMOUNT_MAX && !(overall_lim != 0 && sum > 64'(overall_lim)) &&
				    !(owner_lim != 0 && amt > owner_lim)) begin
					// record appears here even if the owner check below refuses
					if (!rec_valid[who]) begin
						rec_valid[who] = 1'b1;
						usage_tbl[who] = '0;
					end
					mine = 64'(usage_tbl[who]) + 64'(amt);
					if (mine <= AMOUNT_MAX && !(owner_lim != 0 && mine > 64'(owner_lim))) begin
						usage_tbl[who] = amt_t'(mine);
						total_used     = amt_t'(sum);
						ok             = 1'b1;
					end
				end
			end
			CMD_RELEASE: begin
				if (rec_valid[who] && usage_tbl[who] >= amt) begin
					usage_tbl[who] = usage_tbl[who] - amt;
					total_used     = (total_used >= amt) ? total_used - amt : '0;
					if (usage_tbl[who] == '0)
						rec_valid[who] = 1'b0;
					ok = 1'b1;
				end
			end
			CMD_CLEAR: begin
				foreach (rec_valid[i])
					rec_valid[i] = 1'b0;
				total_used = '0;
				ok         = 1'b1;
			end
			default: ;
		endcase
		r.granted    = ok;
		r.usage      = rec_valid[who] ? usage_tbl[who] : '0;
		r.space_left = (owner_lim != 0 && owner_lim > r.usage) ? owner_lim - r.usage : '0;
		r.total      = total_used;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		quota_reply_t want;
		if (!arst_n) begin
			overall_lim = '0;
			owner_lim   = '0;
			total_used  = '0;
			foreach (rec_valid[i])
				rec_valid[i] = 1'b0;
			quota_replies.delete();
			pending_replies = 0;
			mismatch_count  = 0;
		end else begin
			if ($isunknown(done)) begin
				$error("done: expected a known value, got %b", done);
				mismatch_count++;
			end else if (done) begin
				if (quota_replies.size() == 0) begin
					$error("result with no pending transaction");
					mismatch_count++;
				end else begin
					want = quota_replies.pop_front();
					if (granted !== want.granted) begin
						$error("granted: expected %0d, got %0d", want.granted, granted);
						mismatch_count++;
					end
					if (owner_usage !== want.usage) begin
						$error("owner_usage: expected %0d, got %0d", want.usage, owner_usage);
						mismatch_count++;
					end
					if (owner_space_left !== want.space_left) begin
						$error("owner_space_left: expected %0d, got %0d", want.space_left,
						       owner_space_left);
						mismatch_count++;
					end
					if (total_usage !== want.total) begin
						$error("total_usage: expected %0d, got %0d", want.total, total_usage);
						mismatch_count++;
					end
				end
			end
			if (start && !busy)
				quota_replies.push_back(apply_request(cmd_e_t'(command), owner_id, amount));
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_OVERALL_LIMIT: overall_lim = amt_t'(pwdata[LIMIT_BITS-1:0]);
					ADDR_OWNER_LIMIT:   owner_lim   = amt_t'(pwdata[LIMIT_BITS-1:0]);
					default: ;
				endcase
			end
			pending_replies = quota_replies.size();
		end
	end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Bench for the memory quota tracker. Drives allocate, release, clear and
// unused commands with random gaps, reprograms both limits between phases,
// and leaves all checking to the quota checker beside the block.
// ----------------------------------------------------------------------------
module tb
	import mqt_pkg::*, mqt_tb_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OWNER_BITS      = OWNER_BITS_DEF;
	localparam int AMOUNT_BITS     = AMOUNT_BITS_DEF;
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int SETTLE_CYCLES   = 4;
	localparam int ITEMS_PER_PHASE = 115;

	typedef logic [AMOUNT_BITS-1:0] amt_t;
	typedef logic [OWNER_BITS-1:0]  owner_t;

	typedef struct {
		owner_t who;
		amt_t   amt;
	} alloc_rec_t;

	localparam amt_t AMOUNT_MAX = '1;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic [1:0]  command;
	owner_t      owner_id;
	amt_t        amount;
	logic        busy;
	logic        done;
	logic        granted;
	amt_t        owner_usage;
	amt_t        owner_space_left;
	amt_t        total_usage;
	int          pending_replies;
	int          mismatch_count;

	owner_t      owner_pool [8];
	alloc_rec_t  alloc_log[$];
	int          burst_left = 0;
	int          idle_cycles = 0;

	memory_quota_tracker #(
		.OWNER_BITS (OWNER_BITS),
		.AMOUNT_BITS(AMOUNT_BITS)
	) u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.start           (start),
		.command         (command),
		.owner_id        (owner_id),
		.amount          (amount),
		.busy            (busy),
		.done            (done),
		.granted         (granted),
		.owner_usage     (owner_usage),
		.owner_space_left(owner_space_left),
		.total_usage     (total_usage)
	);

	mqt_quota_checker #(
		.OWNER_BITS (OWNER_BITS),
		.AMOUNT_BITS(AMOUNT_BITS)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.owner_id        (owner_id),
		.amount          (amount),
		.done            (done),
		.granted         (granted),
		.owner_usage     (owner_usage),
		.owner_space_left(owner_space_left),
		.total_usage     (total_usage),
		.pending_replies (pending_replies),
		.mismatch_count  (mismatch_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// mostly short gaps, a few long ones, and occasional back-to-back bursts
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic owner_t pick_owner();
		if ($urandom_range(0, 99) < 85)
			return owner_pool[$urandom_range(0, 7)];
		return owner_t'($urandom);
	endfunction

	function automatic amt_t pick_amount(amt_t base);
		int unsigned r;
		longint      near;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 55)
			return amt_t'($urandom_range(0, base / 4 + 1));
		if (r < 75)
			return amt_t'($urandom_range(0, base));
		if (r < 88) begin
			near = longint'(base) + longint'(int'($urandom_range(0, 4))) - 2;
			if (near < 0)
				near = 0;
			if (near > longint'(AMOUNT_MAX))
				near = longint'(AMOUNT_MAX);
			return amt_t'(near);
		end
		return amt_t'($urandom);
	endfunction

	task automatic send_request(input cmd_e_t cmd, input owner_t who, input amt_t amt);
		int gap;
		@(negedge clk);
		start    <= 1'b1;
		command  <= cmd;
		owner_id <= who;
		amount   <= amt;
		do @(posedge clk); while (busy);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [2:0] addr, input amt_t value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {1'($urandom_range(0, 1)), value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_limits(input amt_t overall, input amt_t owner_cap);
		write_reg(ADDR_OVERALL_LIMIT, overall);
		write_reg(ADDR_OWNER_LIMIT, owner_cap);
	endtask

	// drop start, drain every outstanding reply, then let the pipe empty
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_replies != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input amt_t overall, input amt_t owner_cap, input int n);
		int         issued;
		int         r;
		int         idx;
		amt_t       base;
		owner_t     who;
		amt_t       amt;
		alloc_rec_t rec;
		issued = 0;
		settle();
		if ($urandom_range(0, 1)) begin
			send_request(CMD_CLEAR, owner_t'($urandom), amt_t'($urandom));
			settle();
		end
		write_limits(overall, owner_cap);
		foreach (owner_pool[i])
			owner_pool[i] = owner_t'($urandom);
		if ($urandom_range(0, 1))
			owner_pool[0] = '0;
		if ($urandom_range(0, 1))
			owner_pool[7] = '1;
		alloc_log.delete();
		if (owner_cap != 0)
			base = owner_cap;
		else if (overall != 0)
			base = overall;
		else
			base = amt_t'(1 << 20);
		while (issued < n) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				who = pick_owner();
				amt = pick_amount(base);
				alloc_log.push_back('{who, amt});
				if (alloc_log.size() > 64)
					void'(alloc_log.pop_front());
				send_request(CMD_ALLOC, who, amt);
			end else if (r < 78) begin
				// give back an earlier allocation so records drain to zero
				if (alloc_log.size() != 0 && $urandom_range(0, 4) != 0) begin
					idx = $urandom_range(0, alloc_log.size() - 1);
					rec = alloc_log[idx];
					alloc_log.delete(idx);
					send_request(CMD_RELEASE, rec.who, rec.amt);
				end else begin
					send_request(CMD_RELEASE, pick_owner(), pick_amount(base));
				end
			end else if (r < 86) begin
				send_request(CMD_ALLOC, owner_t'($urandom), amt_t'($urandom));
			end else if (r < 93) begin
				send_request(CMD_RELEASE, pick_owner(), amt_t'($urandom_range(0, base / 8 + 1)));
			end else if (r < 97) begin
				send_request(CMD_NONE, owner_t'($urandom), amt_t'($urandom));
				issued--;
			end else if (r < 98) begin
				send_request(CMD_CLEAR, pick_owner(), amt_t'($urandom));
				alloc_log.delete();
			end else begin
				send_request(CMD_ALLOC, pick_owner(), '0);
			end
			issued++;
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		start    = 1'b0;
		command  = CMD_ALLOC;
		owner_id = '0;
		amount   = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// unlimited: zero amounts, overflow, releases, unused command, clear
		send_request(CMD_ALLOC, '0, '0);
		send_request(CMD_ALLOC, '1, amt_t'(100));
		send_request(CMD_ALLOC, owner_t'(5), AMOUNT_MAX);
		send_request(CMD_ALLOC, owner_t'(5), AMOUNT_MAX - amt_t'(100));
		send_request(CMD_ALLOC, owner_t'(6), amt_t'(1));
		send_request(CMD_RELEASE, owner_t'(5), AMOUNT_MAX - amt_t'(100));
		send_request(CMD_RELEASE, owner_t'(7), amt_t'(10));
		send_request(CMD_RELEASE, '1, amt_t'(101));
		send_request(CMD_RELEASE, '0, '0);
		send_request(CMD_NONE, '1, AMOUNT_MAX);
		send_request(CMD_CLEAR, owner_t'(512), '0);
		send_request(CMD_RELEASE, '1, '0);

		// both limits active
		settle();
		write_limits(amt_t'(1000), amt_t'(300));
		send_request(CMD_ALLOC, owner_t'(2), amt_t'(301));
		send_request(CMD_ALLOC, owner_t'(2), amt_t'(200));
		send_request(CMD_ALLOC, owner_t'(2), amt_t'(150));
		send_request(CMD_ALLOC, owner_t'(3), amt_t'(150));
		send_request(CMD_ALLOC, owner_t'(8), amt_t'(300));
		send_request(CMD_ALLOC, owner_t'(9), amt_t'(300));
		send_request(CMD_ALLOC, owner_t'(10), amt_t'(100));
		send_request(CMD_ALLOC, owner_t'(10), amt_t'(50));

		// per-owner limit dropped below current usage
		settle();
		write_limits(amt_t'(1000), amt_t'(100));
		send_request(CMD_NONE, owner_t'(2), '0);
		send_request(CMD_RELEASE, owner_t'(2), amt_t'(150));
		send_request(CMD_CLEAR, '0, '0);

		run_phase('0, '0, ITEMS_PER_PHASE);
		run_phase(AMOUNT_MAX, AMOUNT_MAX, ITEMS_PER_PHASE);
		run_phase(amt_t'(1), amt_t'(1), ITEMS_PER_PHASE);
		run_phase(amt_t'(5000), amt_t'(1000), ITEMS_PER_PHASE);
		run_phase('0, amt_t'($urandom_range(1, 100000)), ITEMS_PER_PHASE);
		run_phase(amt_t'($urandom), '0, ITEMS_PER_PHASE);
		run_phase(amt_t'($urandom), amt_t'($urandom), ITEMS_PER_PHASE);
		run_phase(AMOUNT_MAX, '0, ITEMS_PER_PHASE);
		run_phase('0, AMOUNT_MAX, ITEMS_PER_PHASE);
		run_phase(amt_t'(1000), amt_t'(5000), ITEMS_PER_PHASE);
		run_phase(amt_t'($urandom_range(1, 100000)), amt_t'($urandom_range(1, 20000)),
		          ITEMS_PER_PHASE);
		run_phase('0, '0, ITEMS_PER_PHASE);

		settle();
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
